### rtl/crc8fr_pkg.sv
// ----------------------------------------------------------------------------
// crc8fr_pkg: shared definitions for the CRC-8 frame receiver
// Frame constants, status codes, the result record and the CRC-8 byte step.
// ----------------------------------------------------------------------------
package crc8fr_pkg;

	localparam int FIXED_OVERHEAD = 4;
	localparam int MAX_PAYLOAD_DEFAULT = 4;
	localparam int OUT_BYTES = 4;

	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] HEADER_RESET = 8'hAF;
	localparam logic [3:0] MAX_LEN_RESET = 4'd8;

	localparam logic CFG_HEADER = 1'b0;
	localparam logic CFG_MAX_LEN = 1'b1;

	typedef logic [1:0] status_t;
	localparam status_t ST_GOOD = 2'd0;
	localparam status_t ST_CRC_ERR = 2'd1;
	localparam status_t ST_TOO_LONG = 2'd2;

	typedef struct packed {
		logic valid;
		logic [7:0] frame_type;
		logic [7:0] payload_length;
		logic [OUT_BYTES-1:0][7:0] payload;
		status_t status;
	} result_t;

	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc;
		for (int k = 7; k >= 0; k--) begin
			if (c[7] ^ b[k]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### rtl/crc8_uart_frame_receiver.sv
// ----------------------------------------------------------------------------
// crc8_uart_frame_receiver: header / type / length / CRC-8 frame receiver
// Received bytes enter on the input channel (in_valid, in_stall, rx_byte).
// A frame is a header byte, a type byte, a length byte, that many payload
// bytes and a CRC-8 byte (polynomial 0x07, zero start, MSB first) covering
// the header through the last payload byte. Each frame yields one request
// on the output channel (out_valid, out_stall) carrying type, length, up to
// four payload bytes and a status: good, CRC error or too long.
// One byte is accepted every cycle while in_stall is low. The request of a
// frame appears in the output register in the cycle after its CRC byte, or
// after its length byte when too long; bytes ending no frame give no request.
// While the output register holds a request and out_stall is high, in_stall
// is raised and the parser holds its state.
// Reset clears the parser to header hunting, empties the output register,
// and loads the header value 0xAF and the frame length limit 8.
// The configuration port writes register 0 (header value) or 1 (limit)
// on any cycle with cfg_write high.
// ----------------------------------------------------------------------------
module crc8_uart_frame_receiver #(
	parameter int MAX_PAYLOAD = crc8fr_pkg::MAX_PAYLOAD_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           frame_type,
	output logic [7:0]           payload_length,
	output logic [7:0]           payload_byte0,
	output logic [7:0]           payload_byte1,
	output logic [7:0]           payload_byte2,
	output logic [7:0]           payload_byte3,
	output crc8fr_pkg::status_t  frame_status
);
	import crc8fr_pkg::*;

	logic [7:0] header_q;
	logic [3:0] max_len_q;
	logic accept;
	result_t result;
	logic out_valid_q;
	result_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_HEADER: header_q <= cfg_data;
				CFG_MAX_LEN: max_len_q <= cfg_data[3:0];
				default: header_q <= header_q;
			endcase
		end
	end

	assign in_stall = out_valid_q & out_stall;
	assign accept = in_valid & ~in_stall;

	crc8fr_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.rx_byte(rx_byte),
		.header_value(header_q),
		.max_frame_length(max_len_q),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && result.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && result.valid) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_type = out_q.frame_type;
	assign payload_length = out_q.payload_length;
	assign payload_byte0 = out_q.payload[0];
	assign payload_byte1 = out_q.payload[1];
	assign payload_byte2 = out_q.payload[2];
	assign payload_byte3 = out_q.payload[3];
	assign frame_status = out_q.status;

endmodule

### rtl/crc8fr_parser.sv
// ----------------------------------------------------------------------------
// crc8fr_parser: frame parser and CRC-8 accumulator
// Walks the header, type, length, payload and CRC bytes and forms one result
// when a frame ends or is dropped as too long.
// ----------------------------------------------------------------------------
module crc8fr_parser #(
	parameter int MAX_PAYLOAD = crc8fr_pkg::MAX_PAYLOAD_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           header_value,
	input  logic [3:0]           max_frame_length,
	output crc8fr_pkg::result_t  result
);
	import crc8fr_pkg::*;

	localparam int CW = $clog2(MAX_PAYLOAD + 1);
	localparam int PW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [8:0] LIMIT_CAP = 9'(FIXED_OVERHEAD + MAX_PAYLOAD);
	localparam logic [8:0] OVERHEAD = 9'(FIXED_OVERHEAD);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_TYPE,
		PH_LEN,
		PH_DATA,
		PH_CRC
	} phase_t;

	phase_t phase_q;
	logic [7:0] type_q;
	logic [7:0] length_q;
	logic [CW-1:0] count_q;
	logic [7:0] crc_q;
	logic [7:0] store_q [MAX_PAYLOAD];

	logic [8:0] limit;
	logic [8:0] total;
	logic too_long;
	logic [7:0] crc_next;
	logic [CW-1:0] count_inc;
	logic [OUT_BYTES-1:0][7:0] stored;

	assign limit = ({5'd0, max_frame_length} > LIMIT_CAP) ? LIMIT_CAP
		: {5'd0, max_frame_length};
	assign total = {1'b0, rx_byte} + OVERHEAD;
	assign too_long = total > limit;
	assign crc_next = crc8_feed((phase_q == PH_HUNT) ? 8'd0 : crc_q, rx_byte);
	assign count_inc = count_q + CW'(1);

	for (genvar j = 0; j < OUT_BYTES; j++) begin : g_out
		if (j < MAX_PAYLOAD) begin : g_held
			assign stored[j] = (length_q > 8'(j)) ? store_q[j] : 8'd0;
		end else begin : g_none
			assign stored[j] = 8'd0;
		end
	end

	always_comb begin
		result = '0;
		result.frame_type = type_q;
		result.payload_length = length_q;
		unique case (phase_q)
			PH_LEN: begin
				result.valid = too_long;
				result.payload_length = rx_byte;
				result.status = ST_TOO_LONG;
			end
			PH_CRC: begin
				result.valid = 1'b1;
				result.payload = stored;
				result.status = (rx_byte == crc_q) ? ST_GOOD : ST_CRC_ERR;
			end
			default: begin
				result.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			type_q <= 8'd0;
			length_q <= 8'd0;
			count_q <= '0;
			crc_q <= 8'd0;
		end else if (accept) begin
			unique case (phase_q)
				PH_TYPE: begin
					type_q <= rx_byte;
					crc_q <= crc_next;
					phase_q <= PH_LEN;
				end
				PH_LEN: begin
					length_q <= rx_byte;
					if (too_long) begin
						phase_q <= PH_HUNT;
					end else begin
						crc_q <= crc_next;
						count_q <= '0;
						phase_q <= (rx_byte == 8'd0) ? PH_CRC : PH_DATA;
					end
				end
				PH_DATA: begin
					crc_q <= crc_next;
					count_q <= count_inc;
					if (8'(count_inc) >= length_q) begin
						phase_q <= PH_CRC;
					end
				end
				PH_CRC: begin
					phase_q <= PH_HUNT;
				end
				default: begin
					phase_q <= PH_HUNT;
					if (rx_byte == header_value) begin
						crc_q <= crc_next;
						phase_q <= PH_TYPE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_DATA) begin
			store_q[count_q[PW-1:0]] <= rx_byte;
		end
	end

endmodule

### test/crc8_uart_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_uart_frame_receiver_tb: self-checking bench for the CRC-8 deframer
// Sends received bytes through the input channel and predicts every frame
// request with an independent parser model held in a small scoreboard.
// A short directed block covers zero-length, full, bad-CRC and oversized
// frames. Random phases then mix well-formed frames with noise and broken
// frames under several header values and length limits, with random idle
// bursts on both channels except in the final phase.
// ----------------------------------------------------------------------------
module crc8_uart_frame_receiver_tb;
	import crc8fr_pkg::*;

	localparam int PAYLOAD_SLOTS = MAX_PAYLOAD_DEFAULT;

	class frame_scoreboard;
		typedef enum logic [2:0] {HUNT, GET_TYPE, GET_LEN, GET_DATA, GET_CRC} parse_phase_t;
		typedef struct packed {
			logic [7:0] ftype;
			logic [7:0] len;
			logic [3:0][7:0] payload;
			status_t status;
		} frame_rec_t;

		logic [7:0] header_value;
		logic [3:0] max_len;
		parse_phase_t phase;
		logic [7:0] type_hold;
		logic [7:0] length_hold;
		int unsigned byte_count;
		logic [7:0] crc;
		logic [7:0] store [PAYLOAD_SLOTS];
		frame_rec_t pending_frames[$];
		int unsigned errors;
		int unsigned frames_checked;
		int unsigned status_seen [3];

		function new();
			header_value = HEADER_RESET;
			max_len = MAX_LEN_RESET;
			phase = HUNT;
			type_hold = 8'd0;
			length_hold = 8'd0;
			byte_count = 0;
			crc = 8'd0;
			errors = 0;
			frames_checked = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		static function logic [7:0] crc8_step(logic [7:0] c, logic [7:0] d);
			logic [7:0] r;
			r = c ^ d;
			for (int i = 0; i < 8; i++) begin
				r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
			end
			return r;
		endfunction

		function void write_register(logic idx, logic [7:0] d);
			if (idx == CFG_HEADER) begin
				header_value = d;
			end else begin
				max_len = d[3:0];
			end
		endfunction

		function void queue_frame(status_t st, bit with_payload);
			frame_rec_t f;
			f.ftype = type_hold;
			f.len = length_hold;
			for (int j = 0; j < 4; j++) begin
				f.payload[j] = (with_payload && j < PAYLOAD_SLOTS && j < int'(length_hold)) ?
					store[j] : 8'd0;
			end
			f.status = st;
			pending_frames.push_back(f);
		endfunction

		function void note_byte(logic [7:0] b);
			int lim;
			case (phase)
				GET_TYPE: begin
					type_hold = b;
					crc = crc8_step(crc, b);
					phase = GET_LEN;
				end
				GET_LEN: begin
					length_hold = b;
					lim = int'(max_len);
					if (lim > FIXED_OVERHEAD + PAYLOAD_SLOTS) lim = FIXED_OVERHEAD + PAYLOAD_SLOTS;
					if (int'(b) + FIXED_OVERHEAD > lim) begin
						phase = HUNT;
						queue_frame(ST_TOO_LONG, 1'b0);
					end else begin
						crc = crc8_step(crc, b);
						byte_count = 0;
						phase = (b == 8'd0) ? GET_CRC : GET_DATA;
					end
				end
				GET_DATA: begin
					if (byte_count < PAYLOAD_SLOTS) store[byte_count] = b;
					crc = crc8_step(crc, b);
					byte_count++;
					if (byte_count >= int'(length_hold)) phase = GET_CRC;
				end
				GET_CRC: begin
					phase = HUNT;
					queue_frame((b == crc) ? ST_GOOD : ST_CRC_ERR, 1'b1);
				end
				default: begin
					phase = HUNT;
					if (b == header_value) begin
						crc = crc8_step(8'd0, b);
						phase = GET_TYPE;
					end
				end
			endcase
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 30) $display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_frame(logic [7:0] ft, logic [7:0] pl, logic [3:0][7:0] got_pay,
				status_t st);
			frame_rec_t want;
			if (pending_frames.size() == 0) begin
				report($sformatf("unexpected frame type %h length %h status %0d", ft, pl, st));
				return;
			end
			want = pending_frames.pop_front();
			frames_checked++;
			if (ft !== want.ftype)
				report($sformatf("frame_type got %h want %h", ft, want.ftype));
			if (pl !== want.len)
				report($sformatf("payload_length got %h want %h", pl, want.len));
			for (int j = 0; j < 4; j++) begin
				if (got_pay[j] !== want.payload[j])
					report($sformatf("payload_byte%0d got %h want %h", j, got_pay[j],
						want.payload[j]));
			end
			if (st !== want.status)
				report($sformatf("frame_status got %0d want %0d", st, want.status));
			if (want.status <= ST_TOO_LONG) status_seen[want.status]++;
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic cfg_index = CFG_HEADER;
	logic [7:0] cfg_data = 8'd0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = 8'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] frame_type;
	logic [7:0] payload_length;
	logic [7:0] payload_byte0;
	logic [7:0] payload_byte1;
	logic [7:0] payload_byte2;
	logic [7:0] payload_byte3;
	status_t frame_status;

	frame_scoreboard sb;
	bit in_idle_on = 1'b1;
	bit out_idle_on = 1'b1;
	bit timed_out = 1'b0;
	logic [7:0] cur_header = HEADER_RESET;
	logic [3:0] cur_limit = MAX_LEN_RESET;
	int unsigned bytes_accepted = 0;
	int unsigned settings_used = 1;

	crc8_uart_frame_receiver u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_type(frame_type),
		.payload_length(payload_length),
		.payload_byte0(payload_byte0),
		.payload_byte1(payload_byte1),
		.payload_byte2(payload_byte2),
		.payload_byte3(payload_byte3),
		.frame_status(frame_status)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("crc8_uart_frame_receiver_tb: done, errors");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (out_valid && !out_stall)
				sb.check_frame(frame_type, payload_length,
					{payload_byte3, payload_byte2, payload_byte1, payload_byte0}, frame_status);
			if (in_valid && !in_stall) begin
				sb.note_byte(rx_byte);
				bytes_accepted++;
			end
			if (cfg_write) sb.write_register(cfg_index, cfg_data);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (out_idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (in_idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			rx_byte <= 8'($urandom);
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_frame(input logic [7:0] ftype, input logic [7:0] len,
			input logic [31:0] data, input bit corrupt);
		logic [7:0] crc;
		int lim;
		lim = int'(cur_limit);
		if (lim > FIXED_OVERHEAD + PAYLOAD_SLOTS) lim = FIXED_OVERHEAD + PAYLOAD_SLOTS;
		crc = frame_scoreboard::crc8_step(8'd0, cur_header);
		send_byte(cur_header);
		crc = frame_scoreboard::crc8_step(crc, ftype);
		send_byte(ftype);
		send_byte(len);
		if (int'(len) + FIXED_OVERHEAD > lim) return;
		crc = frame_scoreboard::crc8_step(crc, len);
		for (int i = 0; i < int'(len); i++) begin
			crc = frame_scoreboard::crc8_step(crc, data[8*i +: 8]);
			send_byte(data[8*i +: 8]);
		end
		send_byte(corrupt ? (crc ^ 8'($urandom_range(1, 255))) : crc);
	endtask

	task automatic set_config(input logic [7:0] hdr, input logic [3:0] lim);
		cfg_write <= 1'b1;
		cfg_index <= CFG_HEADER;
		cfg_data <= hdr;
		@(posedge clk);
		cfg_index <= CFG_MAX_LEN;
		cfg_data <= {4'd0, lim};
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		cur_header = hdr;
		cur_limit = lim;
		settings_used++;
	endtask

	task automatic drain();
		int waited;
		in_valid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (sb.pending_frames.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		if (sb.pending_frames.size() != 0) timed_out = 1'b1;
		repeat (4) @(posedge clk);
	endtask

	task automatic run_traffic(input int budget);
		int sent;
		int pick;
		int extra;
		int lim;
		logic [7:0] len;
		logic [31:0] data;
		sent = 0;
		lim = int'(cur_limit);
		if (lim > FIXED_OVERHEAD + PAYLOAD_SLOTS) lim = FIXED_OVERHEAD + PAYLOAD_SLOTS;
		while (sent < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				if ($urandom_range(0, 9) == 0)
					len = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(5, 255));
				else
					len = 8'($urandom_range(0, PAYLOAD_SLOTS));
				data = $urandom;
				for (int i = 0; i < 4; i++) begin
					if ($urandom_range(0, 7) == 0) data[8*i +: 8] = cur_header;
				end
				send_frame(8'($urandom), len, data, $urandom_range(0, 6) == 0);
				sent += (int'(len) + FIXED_OVERHEAD <= lim) ? int'(len) + FIXED_OVERHEAD : 3;
			end else if (pick < 88) begin
				send_byte(8'($urandom));
				sent += 1;
			end else begin
				extra = $urandom_range(1, 5);
				send_byte(cur_header);
				repeat (extra) send_byte(8'($urandom));
				sent += extra + 1;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_frame(8'h00, 8'd0, 32'h0, 1'b0);
		send_frame(8'hFF, 8'd4, {8'h55, 8'h00, 8'hFF, 8'hAF}, 1'b0);
		send_frame(8'h12, 8'd1, 32'h0000_0080, 1'b1);
		send_frame(8'h34, 8'd5, 32'h0, 1'b0);
		send_frame(8'h56, 8'hFF, 32'h0, 1'b0);
		send_byte(8'h00);
		drain();

		for (int p = 0; p < 6 && !timed_out; p++) begin
			case (p)
				0: set_config(8'($urandom), 4'd8);
				1: set_config(8'h00, 4'd4);
				2: set_config(8'hFF, 4'd3);
				3: set_config(8'($urandom), 4'd15);
				4: set_config(8'($urandom), 4'($urandom_range(5, 7)));
				default: begin
					set_config(HEADER_RESET, MAX_LEN_RESET);
					in_idle_on = 1'b0;
					out_idle_on = 1'b0;
				end
			endcase
			run_traffic(185);
			drain();
		end

		if (sb.pending_frames.size() != 0)
			sb.report($sformatf("%0d frames never arrived", sb.pending_frames.size()));
		$display("%0d bytes accepted under %0d header/limit settings", bytes_accepted,
			settings_used);
		$display("%0d frames checked: %0d good, %0d bad CRC, %0d too long",
			sb.frames_checked, sb.status_seen[ST_GOOD], sb.status_seen[ST_CRC_ERR],
			sb.status_seen[ST_TOO_LONG]);
		if (!timed_out && sb.errors == 0) begin
			$display("crc8_uart_frame_receiver_tb: done, clean");
		end else begin
			$display("crc8_uart_frame_receiver_tb: done, errors");
		end
		$finish;
	end
endmodule
